// ----- rtl/core/hunk_exe_memory_layout_parser_macros.svh -----
// -----------------------------------------------------------------------------
// Hunk executable parser assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef HUNK_EXE_MEMORY_LAYOUT_PARSER_MACROS_SVH
`define HUNK_EXE_MEMORY_LAYOUT_PARSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HEMP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hemp checker: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define HEMP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hemp checker: next-cycle property failed");

`endif

// ----- rtl/core/hemp_pkg.sv -----
// -----------------------------------------------------------------------------
// hemp_pkg
// Shared constants and types of the hunk executable layout parser.
// -----------------------------------------------------------------------------
package hemp_pkg;

   localparam int MAX_HUNKS = 16;
   // wide enough to hold the hunk count itself
   localparam int CNT_W     = $clog2(MAX_HUNKS + 1);

   localparam logic [31:0] ID_HEADER = 32'h0000_03f3;
   localparam logic [23:0] ID_CODE   = 24'h0003e9;
   localparam logic [23:0] ID_DATA   = 24'h0003ea;
   localparam logic [31:0] ID_RELOC  = 32'h0000_03ec;
   localparam logic [31:0] ID_END    = 32'h0000_03f2;
   localparam int          CHIP_BIT  = 30;
   localparam logic [29:0] SUM_MAX   = 30'h3fff_ffff;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_MAGIC = 2'd1,
      STAT_LIBS      = 2'd2,
      STAT_TOO_MANY  = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [29:0] chip_bytes;
      logic [29:0] other_bytes;
      logic [4:0]  hunks_seen;
      logic [4:0]  marker_errors;
      logic        bad_reloc_target;
   } result_type;

endpackage

// ----- rtl/core/hemp_in_stage.sv -----
// -----------------------------------------------------------------------------
// hemp_in_stage
// Input register for the file word stream; holds one word until the walker
// can consume it.
// -----------------------------------------------------------------------------
module hemp_in_stage (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [31:0] req_word,
   output logic        req_stall,
   input  logic        advance,
   output logic        word_valid,
   output logic [31:0] word
);

   logic        word_valid_ff, word_valid_in;
   logic [31:0] word_ff, word_in;
   logic        accept;

   assign req_stall = word_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      word_valid_in = advance ? 1'b0 : word_valid_ff;
      word_in       = word_ff;
      if (accept) begin
         word_valid_in = 1'b1;
         word_in       = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = word_valid_ff;
   assign word       = word_ff;

endmodule

// ----- rtl/core/hemp_walker.sv -----
// -----------------------------------------------------------------------------
// hemp_walker
// Per-word state machine: header checks, size totals, body and relocation
// skipping, end marker checks and the per-file result.
// -----------------------------------------------------------------------------
module hemp_walker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  logic [31:0]          step_word,
   output logic                 emit_valid,
   output hemp_pkg::result_type emit_result
);

   typedef enum logic [14:0] {
      PH_MAGIC      = 15'b000000000000001,
      PH_LIBS       = 15'b000000000000010,
      PH_COUNT      = 15'b000000000000100,
      PH_FIRST      = 15'b000000000001000,
      PH_LAST       = 15'b000000000010000,
      PH_SIZES      = 15'b000000000100000,
      PH_ID         = 15'b000000001000000,
      PH_LEN_SKIP   = 15'b000000010000000,
      PH_LEN_NOSKIP = 15'b000000100000000,
      PH_BODY       = 15'b000001000000000,
      PH_MARKER     = 15'b000010000000000,
      PH_RCOUNT     = 15'b000100000000000,
      PH_RTARGET    = 15'b001000000000000,
      PH_ROFFS      = 15'b010000000000000,
      PH_MARKER2    = 15'b100000000000000
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [hemp_pkg::CNT_W-1:0]   total_ff, total_in;
   logic [hemp_pkg::CNT_W-1:0]   index_ff, index_in;
   logic [31:0]                  skip_ff, skip_in;
   logic [29:0]                  chip_ff, chip_in;
   logic [29:0]                  other_ff, other_in;
   logic [4:0]                   marker_ff, marker_in;
   logic                         target_ff, target_in;

   logic [hemp_pkg::CNT_W-1:0]   index_inc;
   logic [30:0]                  chip_sum;
   logic [30:0]                  other_sum;
   logic [31:0]                  skip_dec;
   logic                         do_emit;
   hemp_pkg::status_type         emit_status;

   assign index_inc = index_ff + 1'b1;
   assign skip_dec  = skip_ff - 32'd1;
   // size word low 24 bits, in longwords, becomes a 26-bit byte count
   assign chip_sum  = {1'b0, chip_ff}  + 31'({step_word[23:0], 2'b00});
   assign other_sum = {1'b0, other_ff} + 31'({step_word[23:0], 2'b00});

   always_comb begin
      phase_in    = phase_ff;
      total_in    = total_ff;
      index_in    = index_ff;
      skip_in     = skip_ff;
      chip_in     = chip_ff;
      other_in    = other_ff;
      marker_in   = marker_ff;
      target_in   = target_ff;
      do_emit     = 1'b0;
      emit_status = hemp_pkg::STAT_OK;

      if (step_valid) begin
         case (phase_ff)
            PH_MAGIC: begin
               if (step_word != hemp_pkg::ID_HEADER) begin
                  do_emit     = 1'b1;
                  emit_status = hemp_pkg::STAT_BAD_MAGIC;
               end else begin
                  phase_in = PH_LIBS;
               end
            end
            PH_LIBS: begin
               if (step_word != 32'd0) begin
                  do_emit     = 1'b1;
                  emit_status = hemp_pkg::STAT_LIBS;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (step_word > 32'(hemp_pkg::MAX_HUNKS)) begin
                  do_emit     = 1'b1;
                  emit_status = hemp_pkg::STAT_TOO_MANY;
               end else begin
                  total_in = hemp_pkg::CNT_W'(step_word);
                  phase_in = PH_FIRST;
               end
            end
            PH_FIRST: begin
               phase_in = PH_LAST;
            end
            PH_LAST: begin
               if (total_ff == '0) begin
                  do_emit = 1'b1;
               end else begin
                  index_in = '0;
                  phase_in = PH_SIZES;
               end
            end
            PH_SIZES: begin
               if (step_word[hemp_pkg::CHIP_BIT]) begin
                  chip_in = chip_sum[30] ? hemp_pkg::SUM_MAX : chip_sum[29:0];
               end else begin
                  other_in = other_sum[30] ? hemp_pkg::SUM_MAX : other_sum[29:0];
               end
               index_in = index_inc;
               if (index_inc >= total_ff) begin
                  index_in = '0;
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               if (step_word[23:0] inside {hemp_pkg::ID_CODE, hemp_pkg::ID_DATA}) begin
                  phase_in = PH_LEN_SKIP;
               end else begin
                  phase_in = PH_LEN_NOSKIP;
               end
            end
            PH_LEN_SKIP: begin
               skip_in  = step_word;
               phase_in = (step_word != 32'd0) ? PH_BODY : PH_MARKER;
            end
            PH_LEN_NOSKIP: begin
               phase_in = PH_MARKER;
            end
            PH_BODY: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = PH_MARKER;
               end
            end
            PH_MARKER, PH_MARKER2: begin
               if (phase_ff == PH_MARKER && step_word == hemp_pkg::ID_RELOC) begin
                  phase_in = PH_RCOUNT;
               end else begin
                  if (step_word != hemp_pkg::ID_END) begin
                     marker_in = marker_ff + 5'd1;
                  end
                  index_in = index_inc;
                  if (index_inc >= total_ff) begin
                     do_emit = 1'b1;
                  end else begin
                     phase_in = PH_ID;
                  end
               end
            end
            PH_RCOUNT: begin
               if (step_word == 32'd0) begin
                  phase_in = PH_MARKER2;
               end else begin
                  skip_in  = step_word;
                  phase_in = PH_RTARGET;
               end
            end
            PH_RTARGET: begin
               if (step_word >= 32'(total_ff)) begin
                  target_in = 1'b1;
               end
               phase_in = PH_ROFFS;
            end
            PH_ROFFS: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = PH_RCOUNT;
               end
            end
            default: begin
               // unreachable encoding: start over on a clean file
               phase_in  = PH_MAGIC;
               total_in  = '0;
               index_in  = '0;
               skip_in   = '0;
               chip_in   = '0;
               other_in  = '0;
               marker_in = '0;
               target_in = 1'b0;
            end
         endcase
      end

      // error results carry no totals
      emit_result.status           = emit_status;
      emit_result.chip_bytes       = '0;
      emit_result.other_bytes      = '0;
      emit_result.hunks_seen       = '0;
      emit_result.marker_errors    = '0;
      emit_result.bad_reloc_target = 1'b0;
      if (emit_status == hemp_pkg::STAT_OK) begin
         emit_result.chip_bytes       = chip_in;
         emit_result.other_bytes      = other_in;
         emit_result.hunks_seen       = 5'(total_in);
         emit_result.marker_errors    = marker_in;
         emit_result.bad_reloc_target = target_in;
      end

      if (do_emit) begin
         phase_in  = PH_MAGIC;
         total_in  = '0;
         index_in  = '0;
         skip_in   = '0;
         chip_in   = '0;
         other_in  = '0;
         marker_in = '0;
         target_in = 1'b0;
      end
   end

   assign emit_valid = do_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         total_ff  <= '0;
         index_ff  <= '0;
         skip_ff   <= '0;
         chip_ff   <= '0;
         other_ff  <= '0;
         marker_ff <= '0;
         target_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         total_ff  <= total_in;
         index_ff  <= index_in;
         skip_ff   <= skip_in;
         chip_ff   <= chip_in;
         other_ff  <= other_in;
         marker_ff <= marker_in;
         target_ff <= target_in;
      end
   end

endmodule

// ----- rtl/core/hunk_exe_memory_layout_parser.sv -----
// -----------------------------------------------------------------------------
// hunk_exe_memory_layout_parser
// Walks a hunk-format executable word by word and reports its memory layout.
// -----------------------------------------------------------------------------
// Usage:
//   req_ channel carries the file as big-endian 32-bit words, one per
//   transaction. rsp_ channel carries one result per file: status, chip and
//   other memory byte totals, declared hunk count, end marker errors and a
//   bad relocation target flag. Errors (bad magic, library list, too many
//   hunks) give a result at once, with zero totals.
//   Result path: a word that ends a file reaches rsp_valid through the
//   input register, then the result register.
//   Throughput: one word per cycle while rsp_stall holds no pending result;
//   a new word is taken while a finished result waits on rsp_stall.
//   Stall: while rsp_stall holds a pending result, the walker holds and the
//   input register fills, after which req_stall rises.
//   Reset: synchronous; drops any partial file and waits for a magic word.
// -----------------------------------------------------------------------------
module hunk_exe_memory_layout_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [29:0] rsp_chip_bytes,
   output logic [29:0] rsp_other_bytes,
   output logic [4:0]  rsp_hunks_seen,
   output logic [4:0]  rsp_marker_errors,
   output logic        rsp_bad_reloc_target
);

   logic                 advance;
   logic                 word_valid;
   logic [31:0]          word;
   logic                 emit_valid;
   hemp_pkg::result_type emit_result;

   logic                 rsp_valid_ff, rsp_valid_in;
   hemp_pkg::result_type result_ff, result_in;

   // walker may step when the result register is empty or draining
   assign advance = !rsp_valid_ff || !rsp_stall;

   hemp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_stall  (req_stall),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   hemp_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (word_valid && advance),
      .step_word   (word),
      .emit_valid  (emit_valid),
      .emit_result (emit_result)
   );

   always_comb begin
      rsp_valid_in = advance ? emit_valid : rsp_valid_ff;
      result_in    = (advance && emit_valid) ? emit_result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = result_ff.status;
   assign rsp_chip_bytes       = result_ff.chip_bytes;
   assign rsp_other_bytes      = result_ff.other_bytes;
   assign rsp_hunks_seen       = result_ff.hunks_seen;
   assign rsp_marker_errors    = result_ff.marker_errors;
   assign rsp_bad_reloc_target = result_ff.bad_reloc_target;

endmodule

// ----- rtl/core/hemp_checker.sv -----
// -----------------------------------------------------------------------------
// hemp_checker
// Port-level checks of the layout parser, bound to the top level.
// -----------------------------------------------------------------------------
`include "hunk_exe_memory_layout_parser_macros.svh"

module hemp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [29:0] rsp_chip_bytes,
   input logic [29:0] rsp_other_bytes,
   input logic [4:0]  rsp_hunks_seen,
   input logic [4:0]  rsp_marker_errors,
   input logic        rsp_bad_reloc_target
);

   logic [70:0] rsp_totals;
   logic [72:0] rsp_fields;
   logic        rsp_err;
   logic        rsp_ok;

   assign rsp_totals = {rsp_chip_bytes, rsp_other_bytes, rsp_hunks_seen,
                        rsp_marker_errors, rsp_bad_reloc_target};
   assign rsp_fields = {rsp_status, rsp_totals};
   assign rsp_err    = rsp_valid && (rsp_status != hemp_pkg::STAT_OK);
   assign rsp_ok     = rsp_valid && (rsp_status == hemp_pkg::STAT_OK);

   // a held result keeps its status and totals
   `HEMP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields))

   // error results report no totals
   `HEMP_ASSERT_SAME(a_err_zero, rsp_err, rsp_totals == '0)

   // a completed file never declares more hunks than allowed
   `HEMP_ASSERT_SAME(a_ok_count, rsp_ok, 32'(rsp_hunks_seen) <= 32'(hemp_pkg::MAX_HUNKS))

   // the input side stalls only while a result is pending
   `HEMP_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid)

endmodule

bind hunk_exe_memory_layout_parser hemp_checker u_hemp_checker (.*);
